[hdl/kq_pkg.sv]
// Shared constants, codes, types and pointer helpers for the keyed removal queue.
// No dependencies; every other file of the block but kq_ram refers to this package by scope.
package kq_pkg;

  localparam int unsigned CAPACITY = 4096;
  localparam int unsigned PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 17;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned OCC_W    = 13;

  localparam logic [VAL_W-1:0] MAX_VALUE_RST = 17'd100000;

  // command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_DUP       = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd4;
  localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 3'd5;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == '0) begin
      r = PTR_W'(CAPACITY - 1);
    end else begin
      r = p - PTR_W'(1);
    end
    return r;
  endfunction

endpackage

[hdl/kq_cmd_if.sv]
// Command channel of the keyed removal queue: valid/ready with command and identifier.
// Depends on kq_pkg for field widths.
interface kq_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [kq_pkg::CMD_W-1:0]  cmd;
  logic [kq_pkg::VAL_W-1:0]  value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

[hdl/kq_res_if.sv]
// Result channel of the keyed removal queue: valid/ready with status, value and occupancy.
// Depends on kq_pkg for field widths.
interface kq_res_if;
  logic                      valid;
  logic                      ready;
  logic [kq_pkg::STAT_W-1:0] status;
  logic [kq_pkg::VAL_W-1:0]  out_value;
  logic [kq_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, output status, output out_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input out_value, input occupancy,
                  output ready);
endinterface

[hdl/kq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module kq_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 17
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/kq_ctrl.sv]
// Sequencer of the keyed removal queue: command decode, linear search, shift-down removal,
// head pop and the result register. Drives the entry RAM; depends on kq_pkg and both channels.
module kq_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [kq_pkg::VAL_W-1:0] cfg_wdata_i,
  kq_cmd_if.sink                   req_i,
  kq_res_if.source                 rsp_o,
  output kq_pkg::mem_req_t         mem_req_o,
  input  logic [kq_pkg::VAL_W-1:0] mem_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e                      state_q, state_d;
  logic [kq_pkg::CMD_W-1:0]    cmd_q, cmd_d;
  logic [kq_pkg::VAL_W-1:0]    value_q, value_d;
  logic [kq_pkg::VAL_W-1:0]    max_q, max_d;
  logic [kq_pkg::PTR_W-1:0]    head_q, head_d;
  logic [kq_pkg::PTR_W-1:0]    tail_q, tail_d;
  logic [kq_pkg::CNT_W-1:0]    count_q, count_d;
  // read issue: next logical index and its physical address
  logic [kq_pkg::CNT_W-1:0]    ik_q, ik_d;
  logic [kq_pkg::PTR_W-1:0]    ip_q, ip_d;
  // read data arriving this cycle: valid, logical index, physical address
  logic                        cv_q, cv_d;
  logic [kq_pkg::CNT_W-1:0]    ck_q, ck_d;
  logic [kq_pkg::PTR_W-1:0]    cp_q, cp_d;
  // shift write pointer
  logic [kq_pkg::PTR_W-1:0]    wp_q, wp_d;
  logic [kq_pkg::STAT_W-1:0]   pend_status_q, pend_status_d;
  logic [kq_pkg::VAL_W-1:0]    pend_outv_q, pend_outv_d;
  logic                        res_valid_q, res_valid_d;
  logic [kq_pkg::STAT_W-1:0]   res_status_q, res_status_d;
  logic [kq_pkg::VAL_W-1:0]    res_outv_q, res_outv_d;
  logic [kq_pkg::OCC_W-1:0]    res_occ_q, res_occ_d;

  logic accept;
  logic hit;
  logic full;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign hit         = cv_q && (mem_rdata_i == value_q);
  assign full        = (count_q == kq_pkg::CNT_W'(kq_pkg::CAPACITY));

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    value_d       = value_q;
    max_d         = max_q;
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    ik_d          = ik_q;
    ip_d          = ip_q;
    cv_d          = cv_q;
    ck_d          = ck_q;
    cp_d          = cp_q;
    wp_d          = wp_q;
    pend_status_d = pend_status_q;
    pend_outv_d   = pend_outv_q;
    res_valid_d   = res_valid_q;
    res_status_d  = res_status_q;
    res_outv_d    = res_outv_q;
    res_occ_d     = res_occ_q;
    mem_req_o     = '0;

    if (cfg_we_i) begin
      max_d = cfg_wdata_i;
    end

    if (rsp_o.ready) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d         = req_i.cmd;
          value_d       = req_i.value;
          pend_status_d = kq_pkg::STAT_OK;
          pend_outv_d   = '0;
          // read the head on every transaction; pop and search both start there
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = head_q;
          cv_d          = 1'b1;
          ck_d          = '0;
          cp_d          = head_q;
          ik_d          = kq_pkg::CNT_W'(1);
          ip_d          = kq_pkg::ptr_inc(head_q);
          state_d       = S_DONE;
          case (req_i.cmd)
            kq_pkg::CMD_APPEND, kq_pkg::CMD_REMOVE: begin
              if (req_i.value > max_q) begin
                pend_status_d = kq_pkg::STAT_TOO_LARGE;
              end else if (count_q == '0) begin
                if (req_i.cmd == kq_pkg::CMD_APPEND) begin
                  mem_req_o.we    = 1'b1;
                  mem_req_o.waddr = tail_q;
                  mem_req_o.wdata = req_i.value;
                  tail_d          = kq_pkg::ptr_inc(tail_q);
                  count_d         = count_q + kq_pkg::CNT_W'(1);
                end else begin
                  pend_status_d = kq_pkg::STAT_NOT_FOUND;
                end
              end else begin
                state_d = S_SEARCH;
              end
            end
            kq_pkg::CMD_POP: begin
              if (count_q == '0) begin
                pend_status_d = kq_pkg::STAT_EMPTY;
              end else begin
                state_d = S_POP;
              end
            end
            default: begin
              pend_status_d = kq_pkg::STAT_OK;
            end
          endcase
        end
      end

      S_POP: begin
        pend_outv_d = mem_rdata_i;
        head_d      = kq_pkg::ptr_inc(head_q);
        count_d     = count_q - kq_pkg::CNT_W'(1);
        state_d     = S_DONE;
      end

      S_SEARCH: begin
        if (hit) begin
          cv_d = 1'b0;
          if (cmd_q == kq_pkg::CMD_APPEND) begin
            pend_status_d = kq_pkg::STAT_DUP;
            state_d       = S_DONE;
          end else if ((ck_q + kq_pkg::CNT_W'(1)) == count_q) begin
            // last entry: nothing to shift
            tail_d  = kq_pkg::ptr_dec(tail_q);
            count_d = count_q - kq_pkg::CNT_W'(1);
            state_d = S_DONE;
          end else begin
            wp_d    = cp_q;
            ip_d    = kq_pkg::ptr_inc(cp_q);
            ik_d    = ck_q + kq_pkg::CNT_W'(1);
            state_d = S_SHIFT;
          end
        end else if (cv_q && (ck_q == (count_q - kq_pkg::CNT_W'(1)))) begin
          cv_d    = 1'b0;
          state_d = S_DONE;
          if (cmd_q == kq_pkg::CMD_APPEND) begin
            if (full) begin
              pend_status_d = kq_pkg::STAT_FULL;
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = tail_q;
              mem_req_o.wdata = value_q;
              tail_d          = kq_pkg::ptr_inc(tail_q);
              count_d         = count_q + kq_pkg::CNT_W'(1);
            end
          end else begin
            pend_status_d = kq_pkg::STAT_NOT_FOUND;
          end
        end else if (ik_q < count_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ip_q;
          cv_d            = 1'b1;
          ck_d            = ik_q;
          cp_d            = ip_q;
          ik_d            = ik_q + kq_pkg::CNT_W'(1);
          ip_d            = kq_pkg::ptr_inc(ip_q);
        end else begin
          cv_d = 1'b0;
        end
      end

      S_SHIFT: begin
        // move each later entry down by one, one read and one write a cycle
        if (cv_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = wp_q;
          mem_req_o.wdata = mem_rdata_i;
          wp_d            = kq_pkg::ptr_inc(wp_q);
        end
        if (ik_q < count_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ip_q;
          cv_d            = 1'b1;
          ik_d            = ik_q + kq_pkg::CNT_W'(1);
          ip_d            = kq_pkg::ptr_inc(ip_q);
        end else begin
          cv_d = 1'b0;
          if (cv_q) begin
            tail_d  = kq_pkg::ptr_dec(tail_q);
            count_d = count_q - kq_pkg::CNT_W'(1);
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        // hold until the result register is free
        if (!res_valid_q || rsp_o.ready) begin
          res_valid_d  = 1'b1;
          res_status_d = pend_status_q;
          res_outv_d   = pend_outv_q;
          res_occ_d    = kq_pkg::OCC_W'(count_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      max_q        <= kq_pkg::MAX_VALUE_RST;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      cv_q         <= 1'b0;
      res_valid_q  <= 1'b0;
      res_status_q <= '0;
      res_outv_q   <= '0;
      res_occ_q    <= '0;
    end else begin
      state_q      <= state_d;
      max_q        <= max_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      cv_q         <= cv_d;
      res_valid_q  <= res_valid_d;
      res_status_q <= res_status_d;
      res_outv_q   <= res_outv_d;
      res_occ_q    <= res_occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    value_q       <= value_d;
    ik_q          <= ik_d;
    ip_q          <= ip_d;
    ck_q          <= ck_d;
    cp_q          <= cp_d;
    wp_q          <= wp_d;
    pend_status_q <= pend_status_d;
    pend_outv_q   <= pend_outv_d;
  end

  assign rsp_o.valid     = res_valid_q;
  assign rsp_o.status    = res_status_q;
  assign rsp_o.out_value = res_outv_q;
  assign rsp_o.occupancy = res_occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= kq_pkg::CNT_W'(kq_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_tail_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q == kq_pkg::PTR_W'((32'(head_q) + 32'(count_q)) % kq_pkg::CAPACITY))
    else $error("tail pointer out of step with head and count");

  a_search_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) && !(cv_q && (ck_q == (count_q - kq_pkg::CNT_W'(1))))
    |-> !mem_req_o.we)
    else $error("entry write during search");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |=> (count_q == ($past(count_q) - kq_pkg::CNT_W'(1))))
    else $error("pop did not drop one entry");

endmodule

[hdl/keyed_removal_queue_core.sv]
// Keyed removal queue: an ordered FIFO of identifiers held in a single-port-read entry RAM
// used as a circular buffer. A pop reads the head, then goes through the result stage. An
// append or remove searches the held entries one per cycle through the RAM read port, and a
// remove then moves every later entry down one place, one per cycle. One transaction is
// worked at a time; the result register lets the next command in while a result waits. No
// clearing pass after reset.
module keyed_removal_queue_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [kq_pkg::VAL_W-1:0] cfg_wdata_i,
  kq_cmd_if.sink                   req_i,
  kq_res_if.source                 rsp_o
);

  kq_pkg::mem_req_t         mem_req;
  logic [kq_pkg::VAL_W-1:0] mem_rdata;

  kq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  kq_ram #(
    .DEPTH (kq_pkg::CAPACITY),
    .WIDTH (kq_pkg::VAL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule
